// ===== rtl/wav_hdr_pkg.sv =====
// ----------------------------------------------------------------------------
// wav_hdr_pkg: shared types and constants for the RIFF/WAVE header parser
// Request payload types, chunk tags, status codes and the front/back event.
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 32;

	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] TAG_SMPL = 32'h6C706D73;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_RIFF  = 3'd1,
		ST_NOT_PCM   = 3'd2,
		ST_NOT_16    = 3'd3,
		ST_BAD_LOOP  = 3'd4,
		ST_MISSING   = 3'd5,
		ST_BAD_SIZE  = 3'd6,
		ST_TRUNCATED = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		PH_RIFF = 4'b0001,
		PH_HDR  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_HALT = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2,
		KIND_SMPL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       is_last;
	} in_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [30:0] frame_count;
		logic [31:0] data_offset;
		logic        has_loop;
		logic [31:0] loop_start;
		logic [31:0] loop_end;
	} out_req_t;

	// end-of-file summary handed from front to back
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] data_bytes;
		logic [31:0] data_start;
		logic        loop_seen;
		logic [31:0] loop_first;
		logic [31:0] loop_last;
	} summ_t;

endpackage

// ===== rtl/wav_hdr_front.sv =====
// ----------------------------------------------------------------------------
// wav_hdr_front: byte-level RIFF/WAVE parser
// Walks header/chunks one byte a cycle while sum_ready; summary on last byte.
// ----------------------------------------------------------------------------
module wav_hdr_front #(
	parameter int unsigned OFFSET_BITS = wav_hdr_pkg::OFFSET_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  wav_hdr_pkg::in_req_t in_req,
	output logic                 in_ready,
	output logic                 sum_valid,
	output wav_hdr_pkg::summ_t   sum_req,
	input  logic                 sum_ready
);
	localparam logic [OFFSET_BITS:0]   OFS_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};
	localparam logic [OFFSET_BITS-1:0] SIZE_TOP  = {OFFSET_BITS{1'b1}};

	logic [OFFSET_BITS:0]   byte_offset_q;
	wav_hdr_pkg::phase_t    phase_q;
	logic [6:0]             field_shift_q;
	logic [OFFSET_BITS:0]   chunk_end_q;
	wav_hdr_pkg::kind_t     kind_q;
	logic                   seen_fmt_q, seen_data_q, loop_seen_q, loops_here_q;
	logic [15:0]            channels_q;
	logic [31:0]            rate_q, data_bytes_q, data_start_q, loop_first_q, loop_last_q;
	logic [31:0]            shreg_q;
	logic [2:0]             err_q;

	logic [31:0]            sh;
	logic [OFFSET_BITS:0]   off1, size_x, cend_new;
	logic                   take, last_byte;

	// after the byte is taken: what the end check sees
	wav_hdr_pkg::phase_t    ph_n;
	logic [6:0]             fs_n;
	wav_hdr_pkg::kind_t     kind_n;
	logic                   seen_fmt_n, seen_data_n, loop_seen_n, loops_here_n;
	logic [15:0]            ch_n;
	logic [31:0]            rate_n, db_n, ds_n, lf_n, ll_n;
	logic [2:0]             err_n;
	logic [OFFSET_BITS:0]   cend_n;
	logic [2:0]             st_end;

	assign in_ready  = sum_ready;
	assign sum_valid = in_valid && in_req.is_last;
	assign take      = in_valid && in_ready;
	assign last_byte = in_req.is_last;

	assign sh   = {in_req.file_byte, shreg_q[31:8]};
	assign off1 = byte_offset_q + 1'b1;

	always_comb begin
		if (OFFSET_BITS < 32 && sh[31:OFFSET_BITS % 32] != '0 && OFFSET_BITS != 32)
			size_x = {1'b0, SIZE_TOP};
		else
			size_x = (OFFSET_BITS + 1)'(sh);
	end
	assign cend_new = off1 + size_x;

	function automatic logic incomplete(input wav_hdr_pkg::kind_t k, input logic lh,
		input logic [6:0] idx);
		logic r;
		r = 1'b0;
		if (k == wav_hdr_pkg::KIND_FMT) r = idx < 7'd23;
		else if (k == wav_hdr_pkg::KIND_SMPL) r = (idx < 7'd39) || (lh && idx < 7'd59);
		return r;
	endfunction

	always_comb begin
		logic [6:0] i;
		i = field_shift_q;
		ph_n = phase_q; fs_n = field_shift_q; kind_n = kind_q;
		seen_fmt_n = seen_fmt_q; seen_data_n = seen_data_q;
		loop_seen_n = loop_seen_q; loops_here_n = loops_here_q;
		ch_n = channels_q; rate_n = rate_q; db_n = data_bytes_q; ds_n = data_start_q;
		lf_n = loop_first_q; ll_n = loop_last_q; err_n = err_q; cend_n = chunk_end_q;
		if (phase_q != wav_hdr_pkg::PH_HALT) begin
			if (byte_offset_q >= OFS_LIMIT) begin
				if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_BAD_SIZE;
				ph_n = wav_hdr_pkg::PH_HALT;
			end else begin
				if (field_shift_q < 7'd64) fs_n = field_shift_q + 7'd1;
				unique case (phase_q)
					wav_hdr_pkg::PH_RIFF: begin
						if ((i == 7'd3 && sh != wav_hdr_pkg::TAG_RIFF) ||
							(i == 7'd7 && sh == '0) ||
							(i == 7'd11 && sh != wav_hdr_pkg::TAG_WAVE)) begin
							if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_NOT_RIFF;
							ph_n = wav_hdr_pkg::PH_HALT;
						end else if (i == 7'd11) begin
							ph_n = wav_hdr_pkg::PH_HDR; fs_n = '0;
						end
					end
					wav_hdr_pkg::PH_HDR: begin
						if (i == 7'd3) begin
							if (sh == wav_hdr_pkg::TAG_FMT) kind_n = wav_hdr_pkg::KIND_FMT;
							else if (sh == wav_hdr_pkg::TAG_DATA) kind_n = wav_hdr_pkg::KIND_DATA;
							else if (sh == wav_hdr_pkg::TAG_SMPL) kind_n = wav_hdr_pkg::KIND_SMPL;
							else kind_n = wav_hdr_pkg::KIND_OTHER;
						end else if (i == 7'd7) begin
							cend_n = cend_new;
							loops_here_n = 1'b0;
							if (kind_q == wav_hdr_pkg::KIND_DATA) begin
								db_n = 32'(size_x); ds_n = 32'(off1); seen_data_n = 1'b1;
							end else if (kind_q == wav_hdr_pkg::KIND_FMT) begin
								seen_fmt_n = 1'b1;
							end
							ph_n = wav_hdr_pkg::PH_BODY;
							if (off1 >= cend_new) begin
								if (incomplete(kind_q, 1'b0, i)) begin
									if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_TRUNCATED;
									ph_n = wav_hdr_pkg::PH_HALT;
								end else begin
									ph_n = wav_hdr_pkg::PH_HDR; fs_n = '0;
								end
							end
						end
					end
					wav_hdr_pkg::PH_BODY: begin
						if (kind_q == wav_hdr_pkg::KIND_FMT) begin
							if (i == 7'd9 && sh[31:16] != 16'd1) begin
								if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_NOT_PCM;
								ph_n = wav_hdr_pkg::PH_HALT;
							end else if (i == 7'd11) ch_n = sh[31:16];
							else if (i == 7'd15) rate_n = sh;
							else if (i == 7'd23 && sh[31:16] != 16'd16) begin
								if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_NOT_16;
								ph_n = wav_hdr_pkg::PH_HALT;
							end
						end else if (kind_q == wav_hdr_pkg::KIND_SMPL) begin
							if (i == 7'd39 && sh != '0) begin
								loops_here_n = 1'b1; loop_seen_n = 1'b1;
							end else if (loops_here_q && i == 7'd55) lf_n = sh;
							else if (loops_here_q && i == 7'd59) begin
								ll_n = sh;
								if (loop_first_q >= sh) begin
									if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_BAD_LOOP;
									ph_n = wav_hdr_pkg::PH_HALT;
								end
							end
						end
						if (ph_n == wav_hdr_pkg::PH_BODY && off1 >= chunk_end_q) begin
							if (incomplete(kind_q, loops_here_n, i)) begin
								if (err_n == wav_hdr_pkg::ST_OK) err_n = wav_hdr_pkg::ST_TRUNCATED;
								ph_n = wav_hdr_pkg::PH_HALT;
							end else begin
								ph_n = wav_hdr_pkg::PH_HDR; fs_n = '0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// status before the divisibility checks, which the back end runs
	always_comb begin
		st_end = err_n;
		if (err_n == wav_hdr_pkg::ST_OK) begin
			if (ph_n == wav_hdr_pkg::PH_RIFF) st_end = wav_hdr_pkg::ST_TRUNCATED;
			else if (ph_n == wav_hdr_pkg::PH_HDR && fs_n != '0)
				st_end = wav_hdr_pkg::ST_TRUNCATED;
			else if (ph_n == wav_hdr_pkg::PH_BODY &&
				incomplete(kind_n, loops_here_n, fs_n - 7'd1))
				st_end = wav_hdr_pkg::ST_TRUNCATED;
			else if (!seen_fmt_n || !seen_data_n) st_end = wav_hdr_pkg::ST_MISSING;
		end
	end

	always_comb begin
		sum_req.status     = st_end;
		sum_req.channels   = ch_n;
		sum_req.rate       = rate_n;
		sum_req.data_bytes = db_n;
		sum_req.data_start = ds_n;
		sum_req.loop_seen  = loop_seen_n;
		sum_req.loop_first = lf_n;
		sum_req.loop_last  = ll_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0; phase_q <= wav_hdr_pkg::PH_RIFF; field_shift_q <= '0;
			chunk_end_q <= '0; kind_q <= wav_hdr_pkg::KIND_OTHER; seen_fmt_q <= 1'b0;
			seen_data_q <= 1'b0; loop_seen_q <= 1'b0; loops_here_q <= 1'b0;
			channels_q <= '0; rate_q <= '0; data_bytes_q <= '0; data_start_q <= '0;
			loop_first_q <= '0; loop_last_q <= '0; shreg_q <= '0; err_q <= '0;
		end else if (take && last_byte) begin
			byte_offset_q <= '0; phase_q <= wav_hdr_pkg::PH_RIFF; field_shift_q <= '0;
			chunk_end_q <= '0; kind_q <= wav_hdr_pkg::KIND_OTHER; seen_fmt_q <= 1'b0;
			seen_data_q <= 1'b0; loop_seen_q <= 1'b0; loops_here_q <= 1'b0;
			channels_q <= '0; rate_q <= '0; data_bytes_q <= '0; data_start_q <= '0;
			loop_first_q <= '0; loop_last_q <= '0; shreg_q <= '0; err_q <= '0;
		end else if (take) begin
			if (phase_q != wav_hdr_pkg::PH_HALT && byte_offset_q < OFS_LIMIT) begin
				shreg_q <= sh;
				byte_offset_q <= off1;
			end
			phase_q <= ph_n; field_shift_q <= fs_n; chunk_end_q <= cend_n; kind_q <= kind_n;
			seen_fmt_q <= seen_fmt_n; seen_data_q <= seen_data_n;
			loop_seen_q <= loop_seen_n; loops_here_q <= loops_here_n;
			channels_q <= ch_n; rate_q <= rate_n; data_bytes_q <= db_n;
			data_start_q <= ds_n; loop_first_q <= lf_n; loop_last_q <= ll_n; err_q <= err_n;
		end
	end

endmodule

// ===== rtl/wav_hdr_back.sv =====
// ----------------------------------------------------------------------------
// wav_hdr_back: end-of-file summary unit
// Queues summaries, divides data bytes by 2*channels bit-serially, clamps loops.
// ----------------------------------------------------------------------------
module wav_hdr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sum_valid,
	input  wav_hdr_pkg::summ_t    sum_req,
	output logic                  sum_ready,
	output logic                  out_valid,
	output wav_hdr_pkg::out_req_t out_req,
	input  logic                  out_ready
);
	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} bstate_t;

	// two-entry queue in front of the divider
	wav_hdr_pkg::summ_t q_mem_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               q_push, q_pop;

	bstate_t            st_q;
	wav_hdr_pkg::summ_t cur_q;
	logic [31:0]        quo_q;
	logic [32:0]        rem_q;
	logic [5:0]         bit_q;
	logic [32:0]        div_w, rem_sh;
	logic               ge;
	logic [30:0]        frames;
	logic [2:0]         st_fin;
	logic               out_valid_q;
	wav_hdr_pkg::out_req_t out_q;

	assign sum_ready = cnt_q != 2'd2;
	assign q_push    = sum_valid && sum_ready;
	assign q_pop     = st_q == B_IDLE && cnt_q != 2'd0;

	always_ff @(posedge clk) begin
		if (q_push) q_mem_q[wr_ptr_q] <= sum_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (q_push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, q_pop};
		end
	end

	assign div_w  = {16'd0, cur_q.channels, 1'b0};
	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign ge     = rem_sh >= div_w;
	assign frames = quo_q[30:0];

	always_comb begin
		st_fin = cur_q.status;
		if (cur_q.status == wav_hdr_pkg::ST_OK &&
			(div_w == '0 || rem_q != '0)) st_fin = wav_hdr_pkg::ST_BAD_SIZE;
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_mem_q[rd_ptr_q];
		if (q_pop) begin
			quo_q <= q_mem_q[rd_ptr_q].data_bytes; rem_q <= '0; bit_q <= '0;
		end else if (st_q == B_DIV) begin
			// restoring division, one quotient bit a cycle
			quo_q <= {quo_q[30:0], ge};
			rem_q <= ge ? rem_sh - div_w : rem_sh;
			bit_q <= bit_q + 6'd1;
		end
		if (st_q == B_DONE && (!out_valid_q || out_ready)) begin
			out_q.status        <= st_fin;
			out_q.channel_count <= cur_q.channels;
			out_q.sample_rate   <= cur_q.rate;
			out_q.frame_count   <= div_w == '0 ? '0 : frames;
			out_q.data_offset   <= cur_q.data_start;
			out_q.has_loop      <= cur_q.loop_seen;
			out_q.loop_start    <= (cur_q.loop_seen && div_w != '0 &&
				cur_q.loop_first < {1'b0, frames}) ? cur_q.loop_first : '0;
			out_q.loop_end      <= (cur_q.loop_seen && div_w != '0 &&
				cur_q.loop_last < {1'b0, frames}) ? cur_q.loop_last :
				{1'b0, (div_w == '0 ? 31'd0 : frames)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				B_IDLE: if (q_pop) st_q <= B_DIV;
				B_DIV:  if (bit_q == 6'd31) st_q <= B_DONE;
				B_DONE: if (!out_valid_q || out_ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
			if (st_q == B_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_q;

endmodule

// ===== rtl/wav_header_parser_top.sv =====
// Flow: the summary for a file passes from the front end through the two-entry queue,
//   the bit-serial frame-count divider (32 steps) and an output register.
// Throughput: 1 byte per cycle while the queue has room; the divider works on one summary at a time, two files queued.
// Reset: arst_n clears the parser to the start-of-file state and empties the queue.
// ----------------------------------------------------------------------------
// wav_header_parser_top: RIFF/WAVE header parser
// Byte parser front end, summary queue and divider back end.
// ----------------------------------------------------------------------------
module wav_header_parser_top #(
	parameter int unsigned OFFSET_BITS = wav_hdr_pkg::OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wav_hdr_pkg::in_req_t  in_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output wav_hdr_pkg::out_req_t out_req
);
	logic               sum_valid, sum_ready;
	wav_hdr_pkg::summ_t sum_req;

	wav_hdr_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_req, .in_ready,
		.sum_valid, .sum_req, .sum_ready
	);

	wav_hdr_back u_back (
		.clk, .arst_n, .sum_valid, .sum_req, .sum_ready,
		.out_valid, .out_req, .out_ready
	);

`ifndef ASSERT_OFF
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_req.is_last && !in_ready |-> !sum_valid || !sum_ready)
		else $error("summary pushed while full");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_req.channel_count == 16'd0 |-> out_req.status != wav_hdr_pkg::ST_OK)
		else $error("zero channels reported ok");
	a_loop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_req.has_loop |-> out_req.loop_start == 32'd0)
		else $error("loop start without loop");
`endif

endmodule
